>>> rtl/core/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the threshold blob centroid unit.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_FRAC_BITS  = 4;

	localparam int CH_W    = 8;
	localparam int THR_W   = 8;
	localparam int SIZE_W  = 13;
	localparam int OUT_W   = 17;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	localparam int OUT_MAX = 65535;
	localparam int OUT_MIN = -65536;

	localparam int GRAY_SUM_W = 22;
	localparam int GRAY_WB    = 1868;
	localparam int GRAY_WG    = 9617;
	localparam int GRAY_WR    = 4899;
	localparam int GRAY_ROUND = 8192;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam logic [THR_W-1:0]  RST_THRESHOLD = 8'd128;
	localparam logic [SIZE_W-1:0] RST_WIDTH     = 13'd320;
	localparam logic [SIZE_W-1:0] RST_HEIGHT    = 13'd240;

	typedef struct packed {
		logic [THR_W-1:0]  bright_threshold;
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
	} tbc_cfg_t;

	typedef struct packed {
		logic accept;
		logic mul_load;
		logic sel_y;
		logic div_load;
		logic div_step;
		logic store_x;
		logic load_out;
	} tbc_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic empty;
		logic div_last;
		logic out_free;
	} tbc_sts_t;

endpackage

>>> rtl/core/tbc_if.sv
// ----------------------------------------------------------------------------
// tbc_if
// Valid/ready channels for pixel requests and centroid results.
// ----------------------------------------------------------------------------
interface tbc_pixel_if import tbc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface tbc_centre_if import tbc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] centre_x_q4;
	logic signed [OUT_W-1:0] centre_y_q4;
	logic                    blob_found;

	modport source (output valid, output centre_x_q4, output centre_y_q4,
		output blob_found, input ready);
	modport sink   (input valid, input centre_x_q4, input centre_y_q4,
		input blob_found, output ready);
endinterface

>>> rtl/core/tbc_ctrl.sv
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer: pixel intake and the frame-end multiply and divide sequence.
// ----------------------------------------------------------------------------
module tbc_ctrl import tbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tbc_sts_t sts,
	output tbc_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MULX = 3'd1;
	localparam logic [2:0] S_LDX  = 3'd2;
	localparam logic [2:0] S_DIVX = 3'd3;
	localparam logic [2:0] S_MULY = 3'd4;
	localparam logic [2:0] S_LDY  = 3'd5;
	localparam logic [2:0] S_DIVY = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.frame_end) state_d = S_MULX;
			end
			S_MULX: begin
				cmd.mul_load = 1'b1;
				state_d      = sts.empty ? S_OUT : S_LDX;
			end
			S_LDX: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIVX;
			end
			S_DIVX: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_MULY;
			end
			S_MULY: begin
				cmd.store_x  = 1'b1;
				cmd.mul_load = 1'b1;
				cmd.sel_y    = 1'b1;
				state_d      = S_LDY;
			end
			S_LDY: begin
				cmd.div_load = 1'b1;
				cmd.sel_y    = 1'b1;
				state_d      = S_DIVY;
			end
			S_DIVY: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

>>> rtl/core/tbc_dp.sv
// ----------------------------------------------------------------------------
// tbc_dp
// Datapath: gray threshold, position counters, moment sums, shared
// multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module tbc_dp import tbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tbc_cfg_t                cfg,
	input  tbc_cmd_t                cmd,
	output tbc_sts_t                sts,
	input  logic [CH_W-1:0]         blue,
	input  logic [CH_W-1:0]         green,
	input  logic [CH_W-1:0]         red,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] centre_x_q4,
	output logic signed [OUT_W-1:0] centre_y_q4,
	output logic                    blob_found
);

	localparam int POSX_W = $clog2(MAX_WIDTH);
	localparam int POSY_W = $clog2(MAX_HEIGHT);
	localparam int SZX_W  = $clog2(MAX_WIDTH + 1);
	localparam int SZY_W  = $clog2(MAX_HEIGHT + 1);
	localparam int SZ_W   = (SZX_W > SZY_W) ? SZX_W : SZY_W;
	localparam int CNT_W  = POSX_W + POSY_W + 1;
	localparam int SUMX_W = POSX_W + CNT_W;
	localparam int SUMY_W = POSY_W + CNT_W;
	localparam int PROD_W = SZ_W + CNT_W;
	localparam int NUM_W  = FRAC_BITS + SZ_W + CNT_W + 2;
	localparam int REM_W  = CNT_W + 1;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int SW_W   = SZ_W + FRAC_BITS;
	localparam int DIFF_W = (NUM_W + 1 > OUT_W + 1) ? NUM_W + 1 : OUT_W + 1;

	localparam logic signed [DIFF_W-1:0] LIM_HI = DIFF_W'(OUT_MAX);
	localparam logic signed [DIFF_W-1:0] LIM_LO = DIFF_W'(OUT_MIN);

	logic [POSX_W-1:0] col_q;
	logic [POSY_W-1:0] row_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUMX_W-1:0] sumx_q;
	logic [SUMY_W-1:0] sumy_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic signed [OUT_W-1:0] cx_q;
	logic              out_valid_q;

	logic [GRAY_SUM_W-1:0] gray_sum;
	logic [CH_W-1:0]       gray;
	logic                  white;
	logic [SZX_W-1:0]      w_c;
	logic [SZY_W-1:0]      h_c;
	logic [SZ_W-1:0]       size_sel;
	logic                  last_col;
	logic                  last_row;
	logic [NUM_W-1:0]      sxn;
	logic [NUM_W-1:0]      nx;
	logic [NUM_W-1:0]      ny;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        dvsr;
	logic [SW_W-1:0]       swx;
	logic [SW_W-1:0]       swy;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] r;
		r = v;
		if (v > LIM_HI) r = LIM_HI;
		if (v < LIM_LO) r = LIM_LO;
		return r[OUT_W-1:0];
	endfunction

	// gray conversion and threshold
	assign gray_sum = GRAY_SUM_W'(GRAY_WB) * GRAY_SUM_W'(blue)
		+ GRAY_SUM_W'(GRAY_WG) * GRAY_SUM_W'(green)
		+ GRAY_SUM_W'(GRAY_WR) * GRAY_SUM_W'(red)
		+ GRAY_SUM_W'(GRAY_ROUND);
	assign gray  = gray_sum[GRAY_SUM_W-1 -: CH_W];
	assign white = gray > cfg.bright_threshold;

	// clamped frame size
	always_comb begin
		if (cfg.frame_width == '0)                   w_c = SZX_W'(1);
		else if (32'(cfg.frame_width) > MAX_WIDTH)   w_c = SZX_W'(MAX_WIDTH);
		else                                         w_c = SZX_W'(cfg.frame_width);
		if (cfg.frame_height == '0)                  h_c = SZY_W'(1);
		else if (32'(cfg.frame_height) > MAX_HEIGHT) h_c = SZY_W'(MAX_HEIGHT);
		else                                         h_c = SZY_W'(cfg.frame_height);
	end

	assign last_col = (32'(col_q) + 32'd1) >= 32'(w_c);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(h_c);
	assign size_sel = cmd.sel_y ? SZ_W'(h_c) : SZ_W'(w_c);

	// numerators, biased by the scaled size to stay unsigned
	assign sxn = NUM_W'(prod_q) << FRAC_BITS;
	assign nx  = (NUM_W'(sumx_q) << (FRAC_BITS + 1)) + NUM_W'(count_q) + sxn;
	assign ny  = sxn + (sxn << 1) + NUM_W'(count_q) - (NUM_W'(sumy_q) << (FRAC_BITS + 1));

	assign dvsr  = {1'b0, count_q, 1'b0};
	assign trial = {rem_q, num_q[NUM_W-1]};

	assign swx = SW_W'(w_c) << FRAC_BITS;
	assign swy = SW_W'(h_c) << FRAC_BITS;
	assign dx  = $signed(DIFF_W'(num_q)) - $signed(DIFF_W'(swx));
	assign dy  = $signed(DIFF_W'(num_q)) - $signed(DIFF_W'(swy));

	assign sts.frame_end = last_col && last_row;
	assign sts.empty     = count_q == '0;
	assign sts.div_last  = step_q == STEP_W'(NUM_W - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

	// position counters and moment sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			sumx_q  <= '0;
			sumy_q  <= '0;
		end else if (cmd.load_out) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			sumx_q  <= '0;
			sumy_q  <= '0;
		end else if (cmd.accept) begin
			if (white) begin
				count_q <= count_q + CNT_W'(1);
				sumx_q  <= sumx_q + SUMX_W'(col_q);
				sumy_q  <= sumy_q + SUMY_W'(row_q);
			end
			if (!last_col) begin
				col_q <= col_q + POSX_W'(1);
			end else if (!last_row) begin
				col_q <= '0;
				row_q <= row_q + POSY_W'(1);
			end
		end
	end

	// multiplier and restoring divider
	always_ff @(posedge clk) begin
		if (cmd.mul_load) prod_q <= size_sel * count_q;
		if (cmd.store_x)  cx_q   <= sat(dx);
		if (cmd.div_load) begin
			num_q  <= cmd.sel_y ? ny : nx;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
			if (trial >= dvsr) begin
				rem_q <= REM_W'(trial - dvsr);
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[REM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_valid_q <= 1'b0;
		else if (cmd.load_out)  out_valid_q <= 1'b1;
		else if (out_ready)     out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (count_q == '0) begin
				centre_x_q4 <= '0;
				centre_y_q4 <= '0;
				blob_found  <= 1'b0;
			end else begin
				centre_x_q4 <= cx_q;
				centre_y_q4 <= sat(dy);
				blob_found  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/threshold_blob_centroid_unit.sv
// ----------------------------------------------------------------------------
// threshold_blob_centroid_unit
// Centroid of the bright pixels of a raster-order BGR frame.
// ----------------------------------------------------------------------------
// pix carries one BGR pixel per request in raster order; the APB port sets
// the gray threshold and the frame size (byte address 0, 4, 8).
// Every pixel but the last of a frame is taken back to back.
// The last pixel starts the frame-end sequence: a multiply, a divider load
// and NUM_W divide steps for x, the same for y, then a load of the result
// register, NUM_W being FRAC_BITS + size bits + count bits + 2 (44 with the
// default sizes). The one-bit-a-cycle divider is shared by x and y; pix
// is not ready meanwhile.
// An empty frame skips the divider and gives a result with blob_found low.
// cen holds one result in an output register; pixels of the next frame are
// taken while it waits, and a stalled receiver only holds up the next frame
// end. Reset clears counters, sums and the result valid, and sets the
// registers to threshold 128, width 320 and height 240.
// ----------------------------------------------------------------------------
module threshold_blob_centroid_unit import tbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	tbc_pixel_if.sink         pix,
	tbc_centre_if.source      cen,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	tbc_cfg_t cfg_q;
	tbc_cmd_t cmd;
	tbc_sts_t sts;
	logic     wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_threshold <= RST_THRESHOLD;
			cfg_q.frame_width      <= RST_WIDTH;
			cfg_q.frame_height     <= RST_HEIGHT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: cfg_q.bright_threshold <= pwdata[THR_W-1:0];
				REG_WIDTH:     cfg_q.frame_width      <= pwdata[SIZE_W-1:0];
				REG_HEIGHT:    cfg_q.frame_height     <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = APB_DW'(cfg_q.bright_threshold);
			REG_WIDTH:     prdata = APB_DW'(cfg_q.frame_width);
			REG_HEIGHT:    prdata = APB_DW'(cfg_q.frame_height);
			default:       prdata = '0;
		endcase
	end

	tbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.blue        (pix.blue),
		.green       (pix.green),
		.red         (pix.red),
		.out_ready   (cen.ready),
		.out_valid   (cen.valid),
		.centre_x_q4 (cen.centre_x_q4),
		.centre_y_q4 (cen.centre_y_q4),
		.blob_found  (cen.blob_found)
	);

endmodule

>>> tb/tb_threshold_blob_centroid_unit.sv
// ----------------------------------------------------------------------------
// tb_threshold_blob_centroid_unit
// Self-checking bench for the threshold blob centroid unit: a table of
// directed frames (colour extremes, threshold edges, clamped sizes, rounding
// ties, a size change part way through a frame) followed by random frames of
// small sizes, with random gaps on the pixel side and random stalls on the
// centroid side; each result is held to the table or a bit-true frame model.
// ----------------------------------------------------------------------------
module tb_threshold_blob_centroid_unit;
	import tbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS   = 820;
	localparam int          SETTLE_CYCLES  = 100;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	localparam int unsigned W_BLUE    = 1868;
	localparam int unsigned W_GREEN   = 9617;
	localparam int unsigned W_RED     = 4899;
	localparam int unsigned GRAY_HALF = 8192;
	localparam longint unsigned STEP  = longint'(1) << DEF_FRAC_BITS;

	typedef struct packed {
		logic signed [OUT_W-1:0] cx;
		logic signed [OUT_W-1:0] cy;
		logic                    found;
	} centroid_t;

	typedef struct packed {
		logic [THR_W-1:0]  thr;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [12:0]       reps;
		logic [CH_W-1:0]   b;
		logic [CH_W-1:0]   g;
		logic [CH_W-1:0]   r;
		logic              known;
		centroid_t         want;
	} dir_row_t;

	dir_row_t dir_rows [22] = '{
		'{128, 1, 1, 1, 0, 0, 0, 1, '{0, 0, 0}},
		'{128, 1, 1, 1, 255, 255, 255, 1, '{-8, 8, 1}},
		'{128, 1, 1, 1, 255, 0, 0, 1, '{0, 0, 0}},
		'{128, 1, 1, 1, 0, 255, 0, 1, '{-8, 8, 1}},
		'{128, 1, 1, 1, 0, 0, 255, 1, '{0, 0, 0}},
		'{128, 1, 1, 1, 128, 128, 128, 1, '{0, 0, 0}},
		'{128, 1, 1, 1, 129, 129, 129, 1, '{-8, 8, 1}},
		'{255, 1, 1, 1, 255, 255, 255, 1, '{0, 0, 0}},
		'{0, 1, 1, 1, 0, 0, 0, 1, '{0, 0, 0}},
		'{0, 1, 1, 1, 1, 1, 1, 1, '{-8, 8, 1}},
		'{128, 0, 0, 1, 255, 255, 255, 1, '{-8, 8, 1}},
		'{128, 34, 1, 31, 255, 255, 255, 0, '{0, 0, 0}},
		'{128, 34, 1, 1, 0, 0, 0, 0, '{0, 0, 0}},
		'{128, 34, 1, 1, 255, 255, 255, 0, '{0, 0, 0}},
		'{128, 34, 1, 1, 0, 0, 0, 0, '{0, 0, 0}},
		'{128, 1, 34, 31, 255, 255, 255, 0, '{0, 0, 0}},
		'{128, 1, 34, 1, 0, 0, 0, 0, '{0, 0, 0}},
		'{128, 1, 34, 1, 255, 255, 255, 0, '{0, 0, 0}},
		'{128, 1, 34, 1, 0, 0, 0, 0, '{0, 0, 0}},
		'{128, 4, 4, 5, 255, 255, 255, 0, '{0, 0, 0}},
		'{128, 2, 4, 1, 0, 0, 0, 0, '{0, 0, 0}},
		'{128, 2, 1, 2, 255, 255, 255, 0, '{0, 0, 0}}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tbc_pixel_if  pix_if ();
	tbc_centre_if cen_if ();

	threshold_blob_centroid_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_if),
		.cen     (cen_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// frame model state and register copies
	longint unsigned   x_pos, y_pos, hits, acc_x, acc_y;
	logic [THR_W-1:0]  thr_cfg;
	logic [SIZE_W-1:0] width_cfg;
	logic [SIZE_W-1:0] height_cfg;

	centroid_t   centroid_q [$];
	bit          quiet;
	int          fails;
	int unsigned idle_cycles;

	function automatic longint unsigned size_used(input logic [SIZE_W-1:0] v,
			input longint unsigned max);
		if (v == 0)
			return 1;
		if (v > max)
			return max;
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return v[OUT_W-1:0];
	endfunction

	function automatic bit centroid_step(input logic [CH_W-1:0] b, g, r,
			output centroid_t res);
		int unsigned gray;
		longint unsigned w, h, n, sw, sh, nx, ny;
		longint cx, cy;
		res = '0;
		gray = (W_BLUE * b + W_GREEN * g + W_RED * r + GRAY_HALF) >> 14;
		w = size_used(width_cfg, DEF_MAX_WIDTH);
		h = size_used(height_cfg, DEF_MAX_HEIGHT);
		if (gray > thr_cfg) begin
			hits += 1;
			acc_x += x_pos;
			acc_y += y_pos;
		end
		if (x_pos + 1 < w) begin
			x_pos += 1;
			return 1'b0;
		end
		if (y_pos + 1 < h) begin
			x_pos = 0;
			y_pos += 1;
			return 1'b0;
		end
		if (hits != 0) begin
			n = hits;
			sw = STEP * w;
			sh = STEP * h;
			// biased by one step of the frame size so the division stays unsigned
			nx = 2 * STEP * acc_x + n + sw * n;
			ny = sh * n + n + 2 * n * sh - 2 * STEP * acc_y;
			cx = longint'(nx / (2 * n)) - longint'(sw);
			cy = longint'(ny / (2 * n)) - longint'(sh);
			res.cx = clamp_out(cx);
			res.cy = clamp_out(cy);
			res.found = 1'b1;
		end
		x_pos = 0;
		y_pos = 0;
		hits = 0;
		acc_x = 0;
		acc_y = 0;
		return 1'b1;
	endfunction

	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [APB_DW-1:0] want);
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== want) begin
			$error("prdata: expected %0h, actual %0h", want, rd);
			fails++;
		end
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, idx, value, rd);
		case (idx)
			REG_THRESHOLD: begin
				thr_cfg = value[THR_W-1:0];
				reg_check(idx, APB_DW'(thr_cfg));
			end
			REG_WIDTH: begin
				width_cfg = value[SIZE_W-1:0];
				reg_check(idx, APB_DW'(width_cfg));
			end
			default: begin
				height_cfg = value[SIZE_W-1:0];
				reg_check(idx, APB_DW'(height_cfg));
			end
		endcase
	endtask

	// only touched once every pending result is back and the unit has gone quiet
	task automatic configure(input logic [THR_W-1:0] thr, input logic [SIZE_W-1:0] w,
			input logic [SIZE_W-1:0] h);
		logic [APB_DW-1:0] junk;
		pix_if.valid <= 1'b0;
		while (centroid_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		junk = $urandom();
		cfg_write(REG_THRESHOLD, {junk[APB_DW-1:THR_W], thr});
		junk = $urandom();
		cfg_write(REG_WIDTH, {junk[APB_DW-1:SIZE_W], w});
		junk = $urandom();
		cfg_write(REG_HEIGHT, {junk[APB_DW-1:SIZE_W], h});
	endtask

	task automatic send_pixel(input logic [CH_W-1:0] b, g, r, input logic known,
			input centroid_t want);
		int gap;
		centroid_t res;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.blue <= b;
		pix_if.green <= g;
		pix_if.red <= r;
		do @(posedge clk); while (!pix_if.ready);
		if (centroid_step(b, g, r, res))
			centroid_q.push_back(known ? want : res);
	endtask

	// centroid side: random stalls, compare each result with the oldest request
	initial begin
		int stall;
		centroid_t want;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				cen_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cen_if.ready <= 1'b1;
			do @(posedge clk); while (!cen_if.valid);
			if (centroid_q.size() == 0) begin
				$error("centroid result with no request pending");
				fails++;
			end else begin
				want = centroid_q.pop_front();
				if (cen_if.centre_x_q4 !== want.cx) begin
					$error("centre_x_q4: expected %0d, actual %0d", want.cx,
						cen_if.centre_x_q4);
					fails++;
				end
				if (cen_if.centre_y_q4 !== want.cy) begin
					$error("centre_y_q4: expected %0d, actual %0d", want.cy,
						cen_if.centre_y_q4);
					fails++;
				end
				if (cen_if.blob_found !== want.found) begin
					$error("blob_found: expected %0d, actual %0d", want.found,
						cen_if.blob_found);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_if.valid && pix_if.ready) || (cen_if.valid && cen_if.ready)
				|| (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int sent;
		int burst;
		logic [CH_W-1:0] lvl;
		logic [3*CH_W-1:0] bgr;
		logic [THR_W-1:0] thr;
		fails = 0;
		quiet = 1'b0;
		thr_cfg = RST_THRESHOLD;
		width_cfg = RST_WIDTH;
		height_cfg = RST_HEIGHT;
		x_pos = 0;
		y_pos = 0;
		hits = 0;
		acc_x = 0;
		acc_y = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.blue <= '0;
		pix_if.green <= '0;
		pix_if.red <= '0;
		cen_if.ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_check(REG_THRESHOLD, APB_DW'(RST_THRESHOLD));
		reg_check(REG_WIDTH, APB_DW'(RST_WIDTH));
		reg_check(REG_HEIGHT, APB_DW'(RST_HEIGHT));

		foreach (dir_rows[i]) begin
			configure(dir_rows[i].thr, dir_rows[i].w, dir_rows[i].h);
			repeat (dir_rows[i].reps)
				send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r,
					dir_rows[i].known, dir_rows[i].want);
		end

		// random frames, burst lengths unrelated to the frame size
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: thr = '0;
				1: thr = '1;
				default: thr = THR_W'($urandom_range(0, 255));
			endcase
			configure(thr, SIZE_W'($urandom_range(0, 9)), SIZE_W'($urandom_range(0, 6)));
			burst = $urandom_range(20, 80);
			repeat (burst) begin
				if ($urandom_range(0, 3) == 0) begin
					lvl = thr_cfg + CH_W'($urandom_range(0, 1));
					bgr = {lvl, lvl, lvl};
				end else begin
					bgr = 24'($urandom());
				end
				send_pixel(bgr[23:16], bgr[15:8], bgr[7:0], 1'b0, '0);
			end
			sent += burst;
		end

		pix_if.valid <= 1'b0;
		while (centroid_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tbc_pkg.sv
rtl/core/tbc_if.sv
rtl/core/tbc_ctrl.sv
rtl/core/tbc_dp.sv
rtl/core/threshold_blob_centroid_unit.sv
tb/tb_threshold_blob_centroid_unit.sv
